// ===== rtl/lpsc_pkg.sv =====
// Shared types and constants for the length-prefixed to start-code converter.
// No dependencies; imported by lpsc_parse and length_prefixed_to_start_code.
package lpsc_pkg;

  localparam int SAMPLE_LENGTH_BITS = 24;
  localparam int LEN_W = SAMPLE_LENGTH_BITS;
  localparam int UNIT_W = 32;

  localparam logic [2:0] PREFIX_RESET = 3'd4;
  localparam logic [2:0] SC_BEATS = 3'd4;

  localparam logic [7:0] START_CODE [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  // What one accepted input byte produces.
  typedef struct packed {
    logic       has;      // at least one result beat
    logic       sc;       // four start-code beats
    logic [7:0] data;     // payload byte (or zero for an end marker)
    logic       bvalid;   // data carries a stream byte
    logic       send;     // closes the sample
    logic       ok;       // with send: a unit was emitted
  } lpsc_res_t;

endpackage

// ===== rtl/lpsc_parse.sv =====
// Sample parser: per-byte prefix/payload/drop tracking and result selection.
// Depends on lpsc_pkg. Result is combinational from the accepted byte.
module lpsc_parse (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [7:0]                 data_byte,
  input  logic [lpsc_pkg::LEN_W-1:0] sample_length,
  input  logic [2:0]                 pfx_width,
  output lpsc_pkg::lpsc_res_t        res
);
  import lpsc_pkg::*;

  typedef enum logic [1:0] {PH_PREFIX, PH_PAYLOAD, PH_DROP} phase_t;

  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  latch_r, latch_nxt;
  phase_t            phase_r, phase_nxt;
  logic [1:0]        pcnt_r, pcnt_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic              emitted_r, emitted_nxt;

  logic [LEN_W-1:0]  len_raw, len, room;
  logic [LEN_W:0]    pos_inc;
  logic              last, no_room;
  logic [2:0]        w, pcnt_inc;
  logic [UNIT_W-1:0] unit_shift;

  always_comb begin
    unique case (pfx_width)
      3'd1, 3'd2, 3'd3, 3'd4: w = pfx_width;
      3'd0:                   w = 3'd1;
      default:                w = 3'd4;
    endcase
  end

  assign len_raw    = (pos_r == '0) ? sample_length : latch_r;
  assign len        = (len_raw == '0) ? LEN_W'(1) : len_raw;
  assign pos_inc    = {1'b0, pos_r} + (LEN_W+1)'(1);
  assign last       = (pos_inc >= {1'b0, len});
  assign room       = (pos_inc <= {1'b0, len}) ? LEN_W'({1'b0, len} - pos_inc) : '0;
  assign no_room    = (({1'b0, pos_r} + (LEN_W+1)'(w)) > {1'b0, len});
  assign unit_shift = {unit_r[UNIT_W-9:0], data_byte};
  assign pcnt_inc   = {1'b0, pcnt_r} + 3'd1;

  always_comb begin
    pos_nxt     = LEN_W'(pos_inc);
    latch_nxt   = (pos_r == '0) ? sample_length : latch_r;
    phase_nxt   = phase_r;
    pcnt_nxt    = pcnt_r;
    unit_nxt    = unit_r;
    left_nxt    = left_r;
    emitted_nxt = emitted_r;
    res         = '0;

    unique case (phase_r)
      PH_PAYLOAD: begin
        res.has    = 1'b1;
        res.data   = data_byte;
        res.bvalid = 1'b1;
        res.send   = last;
        res.ok     = last & emitted_r;
        if (left_r <= LEN_W'(1)) begin
          left_nxt  = '0;
          phase_nxt = PH_PREFIX;
          pcnt_nxt  = '0;
          unit_nxt  = '0;
        end else begin
          left_nxt = left_r - LEN_W'(1);
        end
      end
      PH_PREFIX: begin
        if (pcnt_r == '0 && no_room) begin
          phase_nxt = PH_DROP;
        end else begin
          unit_nxt = unit_shift;
          if (pcnt_inc >= w) begin
            pcnt_nxt = '0;
            if (unit_shift == '0 || unit_shift > UNIT_W'(room)) begin
              phase_nxt = PH_DROP;
            end else begin
              res.has     = 1'b1;
              res.sc      = 1'b1;
              res.bvalid  = 1'b1;
              left_nxt    = unit_shift[LEN_W-1:0];
              unit_nxt    = '0;
              emitted_nxt = 1'b1;
              phase_nxt   = PH_PAYLOAD;
            end
          end else begin
            pcnt_nxt = pcnt_inc[1:0];
          end
        end
      end
      default: phase_nxt = PH_DROP;
    endcase

    if (last) begin
      if (!res.has) begin
        res.has    = 1'b1;
        res.data   = '0;
        res.bvalid = 1'b0;
        res.send   = 1'b1;
        res.ok     = emitted_r;
      end
      pos_nxt     = '0;
      latch_nxt   = '0;
      phase_nxt   = PH_PREFIX;
      pcnt_nxt    = '0;
      unit_nxt    = '0;
      left_nxt    = '0;
      emitted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      latch_r   <= '0;
      phase_r   <= PH_PREFIX;
      pcnt_r    <= '0;
      unit_r    <= '0;
      left_r    <= '0;
      emitted_r <= 1'b0;
    end else if (accept) begin
      pos_r     <= pos_nxt;
      latch_r   <= latch_nxt;
      phase_r   <= phase_nxt;
      pcnt_r    <= pcnt_nxt;
      unit_r    <= unit_nxt;
      left_r    <= left_nxt;
      emitted_r <= emitted_nxt;
    end
  end

endmodule

// ===== rtl/length_prefixed_to_start_code.sv =====
// Length-prefixed (AVCC) to start-code (Annex B) converter, top level.
// Depends on lpsc_pkg and lpsc_parse.
//
// Takes one sample byte per beat, sample length on every beat (latched on
// the first byte of a sample), and rewrites each length-prefixed unit as
// 00 00 00 01 followed by its payload. Zero or overrunning lengths and short
// trailing bytes drop the rest of the sample. Rate: one input byte per cycle
// for payload and prefix bytes while out_tready holds; the prefix byte that
// opens a unit produces four start-code beats out of the single output
// register, so the input holds off until the last of them is handed off.
// Input is taken when the output register is empty or is handing off its
// final beat. The parse decision is combinational from the input beat into
// the output register, so a result is presented in the cycle after its input.
module length_prefixed_to_start_code (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,   // prefix width in bytes, 1..4
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // [7:0] data_byte, [31:8] sample_length
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // [7:0] out_byte
  output logic        out_tlast,     // run_last
  output logic [2:0]  out_tuser      // [0] byte_valid, [1] sample_end, [2] sample_ok
);
  import lpsc_pkg::*;

  logic [2:0] prefix_r;
  lpsc_res_t  res;
  logic       in_fire, out_fire;

  // output register: remaining beats and the job they come from
  logic [2:0] cnt_r;
  logic       sc_r;
  logic [7:0] data_r;
  logic       bvalid_r, send_r, ok_r;
  logic [1:0] sc_idx;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;
  assign in_tready = (cnt_r == '0) || (cnt_r == 3'd1 && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= PREFIX_RESET;
    end else if (cfg_wr_en) begin
      prefix_r <= cfg_wr_data;
    end
  end

  lpsc_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_fire),
    .data_byte     (in_tdata[7:0]),
    .sample_length (in_tdata[8 +: LEN_W]),
    .pfx_width     (prefix_r),
    .res           (res)
  );

  // counter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire && res.has) begin
      cnt_r <= res.sc ? SC_BEATS : 3'd1;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  // job payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && res.has) begin
      sc_r     <= res.sc;
      data_r   <= res.data;
      bvalid_r <= res.bvalid;
      send_r   <= res.send;
      ok_r     <= res.ok;
    end
  end

  // start-code beat index: 0 on the first of four beats
  assign sc_idx = 2'(SC_BEATS - cnt_r);

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = sc_r ? START_CODE[sc_idx] : data_r;
  assign out_tlast  = (cnt_r == 3'd1);
  assign out_tuser  = {ok_r, send_r, bvalid_r};

endmodule

// ===== rtl/lpsc_check.sv =====
// Port-level assertions for length_prefixed_to_start_code, bound to the top.
// Depends only on the top level's ports.
module lpsc_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // no new input while a result is stuck
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  // ok only with end of sample
  a_ok_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1])
    else $error("sample_ok without sample_end");

  // end marker alone: zero byte, closes sample, last of its run
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 8'h00 && out_tuser[1] && out_tlast)
    else $error("malformed end marker");

  // sample end is always the last beat of its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("sample_end before run end");

endmodule

bind length_prefixed_to_start_code lpsc_check u_lpsc_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== bench/length_prefixed_to_start_code_tb.sv =====
// Self-checking bench for the length-prefixed to start-code converter.
// Depends on lpsc_pkg (sample length width, prefix reset) and the top level.
// A bit-true predictor runs alongside the DUT and every output beat is checked.
module length_prefixed_to_start_code_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpsc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 10;    // input beats per random phase
  localparam int STALL_CYCLES = 300;   // long output hold-off
  localparam int MAX_PRINTS   = 50;

  // Parser state of the predictor
  typedef enum logic [1:0] {
    PARSE_LEN,
    COPY,
    SKIP
  } parse_state_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [LEN_W-1:0] slen;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       bvalid;
    logic       run_last;
    logic       send;
    logic       ok;
  } out_beat_t;

  // ---------------------------------------------------------------------------
  // DUT hookup. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = 3'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = 32'd0;     // [7:0] data_byte, [31:8] sample_length
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;            // [7:0] out_byte
  logic        out_tlast;            // run_last
  logic [2:0]  out_tuser;            // [0] byte_valid, [1] sample_end, [2] sample_ok

  length_prefixed_to_start_code dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  in_beat_t   pending_bytes[$];    // input beats waiting for the driver
  out_beat_t  expected_beats[$];   // predicted output beats, oldest first
  logic [7:0] build[$];            // sample under construction
  in_beat_t   next_beat;
  out_beat_t  head_beat;

  int items_queued    = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int samples_closed  = 0;
  int cfg_writes      = 0;
  int mismatches      = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  logic in_taken = 1'b0;           // input beat accepted at the last rising edge
  logic stall_on = 1'b0;           // long receiver hold-off in progress

  // Predictor copy of the register and the parser state (reset values).
  logic [2:0]       pfx_reg   = PREFIX_RESET;
  logic [LEN_W-1:0] pos       = '0;
  logic [LEN_W-1:0] samp_len  = '0;
  parse_state_t     st        = PARSE_LEN;
  logic [1:0]       pfx_cnt   = 2'd0;
  logic [31:0]      unit_acc  = 32'd0;
  logic [LEN_W-1:0] copy_left = '0;
  logic             unit_seen = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Out-of-range register codes: 0 behaves as 1, 5..7 behave as 4.
  function automatic int unsigned prefix_width(input logic [2:0] v);
    if (v == 3'd0) return 1;
    if (v > 3'd4) return 4;
    return v;
  endfunction

  function automatic out_beat_t mk_beat(input logic [7:0] b, input logic v, input logic e,
                                        input logic ok);
    out_beat_t r;
    r.data     = b;
    r.bvalid   = v;
    r.run_last = 1'b0;
    r.send     = e;
    r.ok       = e & ok;   // ok only means something on the closing beat
    return r;
  endfunction

  // Advance the parser by one input byte and queue the output beats it causes.
  function automatic void convert_byte(input logic [7:0] b, input logic [LEN_W-1:0] slen);
    int unsigned p, len, w, at, room;
    logic        last;
    out_beat_t   beats[4];
    int          n;
    n = 0;
    if (pos == '0) samp_len = slen;          // length latched on first byte
    p    = pos;
    len  = (samp_len == '0) ? 1 : samp_len;  // zero length acts as one byte
    last = (p + 1 >= len);
    w    = prefix_width(pfx_reg);
    case (st)
      COPY: begin
        beats[n] = mk_beat(b, 1'b1, last, unit_seen);
        n++;
        if (copy_left != '0) copy_left--;
        if (copy_left == '0) begin
          st       = PARSE_LEN;
          pfx_cnt  = 2'd0;
          unit_acc = 32'd0;
        end
      end
      PARSE_LEN: begin
        // too few bytes left for a whole prefix: drop the rest
        if (pfx_cnt == 2'd0 && p + w > len) begin
          st = SKIP;
        end else begin
          unit_acc = {unit_acc[23:0], b};
          // a count already at or past a narrowed width completes here
          if (pfx_cnt + 1 >= w) begin
            at      = p + 1;
            room    = (at <= len) ? len - at : 0;
            pfx_cnt = 2'd0;
            if (unit_acc == 32'd0 || unit_acc > room) begin
              st = SKIP;
            end else begin
              for (int i = 0; i < 4; i++) begin
                beats[n] = mk_beat((i == 3) ? 8'h01 : 8'h00, 1'b1, 1'b0, 1'b0);
                n++;
              end
              copy_left = unit_acc[LEN_W-1:0];
              unit_acc  = 32'd0;
              unit_seen = 1'b1;
              st        = COPY;
            end
          end else begin
            pfx_cnt = pfx_cnt + 2'd1;
          end
        end
      end
      default: st = SKIP;
    endcase
    if (last) begin
      // a dropped byte that closes the sample still gives an end marker
      if (n == 0) begin
        beats[0] = mk_beat(8'h00, 1'b0, 1'b1, unit_seen);
        n = 1;
      end
      samples_closed++;
      pos       = '0;
      samp_len  = '0;
      st        = PARSE_LEN;
      pfx_cnt   = 2'd0;
      unit_acc  = 32'd0;
      copy_left = '0;
      unit_seen = 1'b0;
    end else begin
      pos = pos + 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) beats[i].run_last = 1'b1;
      expected_beats.push_back(beats[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result beat %0d %s got %0h want %0h",
                                results_checked, name, got, want));
  endtask

  // Monitor: everything sampled at the rising edge, where the bench-driven
  // signals are settled (they move on the falling edge).
  always @(posedge clk) begin
    cycle_count++;
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (out_byte %0h)",
                                  out_tdata));
      end else begin
        head_beat = expected_beats.pop_front();
        check_field("out_byte",   out_tdata,    head_beat.data);
        check_field("byte_valid", out_tuser[0], head_beat.bvalid);
        check_field("run_last",   out_tlast,    head_beat.run_last);
        check_field("sample_end", out_tuser[1], head_beat.send);
        check_field("sample_ok",  out_tuser[2], head_beat.ok);
      end
      results_checked++;
    end
    // Prediction runs on the accepted input beat; its results can only show
    // up from the next edge on.
    if (in_taken) begin
      items_accepted++;
      convert_byte(in_tdata[7:0], in_tdata[31:8]);
    end
  end

  // ---------------------------------------------------------------------------
  // Driver and receiver, both on the falling edge
  // ---------------------------------------------------------------------------

  // An offered beat is held until it is taken; then the next one may follow
  // right away, or the sender idles.
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (rst_n && pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_beat = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {next_beat.slen, next_beat.data};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && !stall_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Move the built sample into the driver queue. Only the first byte of a
  // sample carries its real length, when opens is set; later bytes carry junk.
  task automatic flush_sample(input logic [LEN_W-1:0] slen, input logic opens);
    in_beat_t it;
    foreach (build[i]) begin
      it.data = build[i];
      it.slen = LEN_W'($urandom);
      if (i == 0 && opens) it.slen = slen;
      pending_bytes.push_back(it);
      items_queued++;
    end
    build.delete();
  endtask

  // Big-endian unit length, w bytes
  task automatic push_prefix(input logic [31:0] val, input int unsigned w);
    for (int k = w - 1; k >= 0; k--) build.push_back(val[8*k +: 8]);
  endtask

  // Mostly well-formed samples with random payload; some end in a bad unit
  // (zero length or overrun), some are plain noise.
  task automatic queue_sample(input int unsigned w);
    int unsigned nu, len, room, pick;
    logic [31:0] val, span;
    span = (w >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * w)) - 1);
    pick = $urandom_range(99);
    if (pick >= 88) begin
      len = $urandom_range(1, 12);
      repeat (len) build.push_back(rand_byte());
      flush_sample((len == 1 && $urandom_range(1) == 0) ? '0 : LEN_W'(len), 1'b1);
    end else begin
      nu = (pick < 70) ? $urandom_range(1, 3) : $urandom_range(0, 1);
      repeat (nu) begin
        len = $urandom_range(1, 10);
        push_prefix(len, w);
        repeat (len) build.push_back(rand_byte());
      end
      if (pick >= 70) begin
        room = $urandom_range(0, 5);
        case ($urandom_range(2))
          0:       val = 32'd0;
          1:       val = room + 1 + $urandom_range(0, 20);
          default: val = $urandom;
        endcase
        push_prefix(val & span, w);
        repeat (room) build.push_back(rand_byte());
      end else if (w > 1 && $urandom_range(3) == 0) begin
        // trailing bytes too few for another prefix
        repeat ($urandom_range(1, w - 1)) build.push_back(rand_byte());
      end
      flush_sample(LEN_W'(build.size()), 1'b1);
    end
  endtask

  task automatic run_random();
    int target;
    target = items_queued + RANDOM_ITEMS;
    while (items_queued < target) queue_sample(prefix_width(pfx_reg));
  endtask

  // Wait until every queued beat is in and every predicted beat is out, then
  // wait on a little longer, since dropped bytes give nothing to wait for.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_beats.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_prefix(input logic [2:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    pfx_reg      = v;
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_idle(input int s, input int r);
    send_idle_pct = s;
    recv_idle_pct = r;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    set_idle(28, 71);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset width of four bytes.
    // one unit, then two trailing bytes too short for a prefix
    build = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55, 8'h3C, 8'hC3};
    flush_sample(8, 1'b1);
    // zero sample length: a single byte that closes the sample
    build = '{8'hFF};
    flush_sample('0, 1'b1);
    // payload byte that closes the sample
    build = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    flush_sample(6, 1'b1);
    // zero unit length
    build = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h5A};
    flush_sample(5, 1'b1);
    // unit length past the end of the sample
    build = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hA5};
    flush_sample(5, 1'b1);
    wait_drained();

    // one-byte prefixes
    write_prefix(3'd1);
    run_random();
    wait_drained();

    // Width narrowed in the middle of a prefix: two of four bytes are in, the
    // new width of two completes the prefix on the next byte.
    write_prefix(3'd4);
    build = '{8'h00, 8'h00};
    flush_sample(10, 1'b1);
    wait_drained();
    write_prefix(3'd2);
    build = '{8'h03, 8'h11, 8'h22, 8'h33, 8'h00, 8'h02, 8'h44, 8'h55};
    flush_sample('0, 1'b0);
    wait_drained();

    // out-of-range code 0 acts as width one
    set_idle(71, 28);
    write_prefix(3'd0);
    run_random();
    wait_drained();

    // code 7 acts as width four; receiver holds off long while input keeps
    // coming, so the output register fills and in_tready drops
    write_prefix(3'd7);
    fork
      begin
        stall_on = 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_on = 1'b0;
      end
    join_none
    run_random();
    wait_drained();

    // full rate both sides
    set_idle(0, 0);
    write_prefix(3'd3);
    run_random();
    wait_drained();

    write_prefix(3'd2);
    run_random();
    wait_drained();

    // largest sample length with an all-ones prefix: dropped, left open
    write_prefix(3'd4);
    build = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
    flush_sample('1, 1'b1);
    wait_drained();

    $display("Ran %0d input beats, checked %0d output beats, %0d samples closed.",
             items_accepted, results_checked, samples_closed);
    $display("%0d prefix-width writes (1..4 and out-of-range codes), three idle mixes, %0s",
             cfg_writes, "one long output stall, mid-prefix width change.");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d beats still expected",
             cycle_count, expected_beats.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
